// ===== hw/rtl/cfcs_pkg.sv =====
// Package for the cone falloff circle scan block.
// Holds widths, limits, opcodes, the controller state type and the
// command/status structs shared by the controller and the datapath.
package cfcs_pkg;

    localparam int COORD_BITS = 10;
    localparam int SIZE_BITS  = COORD_BITS + 1;
    localparam int RAD_BITS   = 8;
    localparam int PEAK_BITS  = 7;
    localparam int R2_BITS    = 2 * RAD_BITS;
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int D2_BITS    = 2 * COORD_BITS + 1;
    localparam int PROD_BITS  = PEAK_BITS + R2_BITS;
    localparam int DVS_BITS   = R2_BITS + PEAK_BITS - 1;
    localparam int DIV_STEPS  = PEAK_BITS;
    localparam int CNT_BITS   = $clog2(DIV_STEPS);

    localparam int RADIUS_MAX = 255;
    localparam int PEAK_MAX   = 100;

    localparam logic [SIZE_BITS-1:0] COORD_LIMIT = SIZE_BITS'(1 << COORD_BITS);
    localparam logic [SIZE_BITS-1:0] SIZE_RESET  = COORD_LIMIT;

    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_SUM,
        S_MUL,
        S_DIV,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic latch_circle;
        logic capture_point;
        logic square;
        logic sum;
        logic mul;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic active;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

// ===== hw/rtl/cfcs_ctrl.sv =====
// Controller state machine for the cone falloff circle scan block.
// Sequences one scan position through square, sum, multiply, divide, load.
// Depends on cfcs_pkg.
module cfcs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_opcode,
    output logic                o_ready,
    input  cfcs_pkg::t_dp_status i_status,
    output cfcs_pkg::t_dp_cmd    o_cmd
);
    import cfcs_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_opcode == OP_NEXT && i_status.active) begin
                    n_state = S_SQUARE;
                end
            end
            S_SQUARE: n_state = S_SUM;
            S_SUM:    n_state = S_MUL;
            S_MUL:    n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready              = 1'b1;
                o_cmd.latch_circle   = w_accept && i_opcode == OP_START;
                o_cmd.capture_point  = w_accept && i_opcode == OP_NEXT && i_status.active;
            end
            S_SQUARE: o_cmd.square   = 1'b1;
            S_SUM:    o_cmd.sum      = 1'b1;
            S_MUL:    o_cmd.mul      = 1'b1;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_LOAD:   o_cmd.load_out = i_status.out_free;
            default: begin
                o_cmd   = '0;
                o_ready = 1'b0;
            end
        endcase
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command at once");

    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_status.div_done) |=> (r_state == S_DIV))
        else $error("divider left before its last step");

    a_capture_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture_point |=> (r_state == S_SQUARE))
        else $error("captured position not processed");

endmodule

// ===== hw/rtl/cfcs_dp.sv =====
// Datapath for the cone falloff circle scan block: circle and grid registers,
// scan counters, squaring, product, restoring divider and output register.
// Depends on cfcs_pkg.
module cfcs_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cfcs_pkg::t_dp_cmd                  i_cmd,
    output cfcs_pkg::t_dp_status               o_status,
    input  logic                               i_cfg_wr_en,
    input  logic                               i_cfg_index,
    input  logic [cfcs_pkg::SIZE_BITS-1:0]     i_cfg_wdata,
    input  logic [cfcs_pkg::COORD_BITS-1:0]    i_center_x,
    input  logic [cfcs_pkg::COORD_BITS-1:0]    i_center_y,
    input  logic [cfcs_pkg::RAD_BITS-1:0]      i_radius,
    input  logic [cfcs_pkg::PEAK_BITS-1:0]     i_max_intensity,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [cfcs_pkg::COORD_BITS-1:0]    o_point_x,
    output logic [cfcs_pkg::COORD_BITS-1:0]    o_point_y,
    output logic                               o_inside_res,
    output logic [cfcs_pkg::PEAK_BITS-1:0]     o_intensity,
    output logic                               o_last
);
    import cfcs_pkg::*;

    // configuration
    logic [SIZE_BITS-1:0]  r_grid_width;
    logic [SIZE_BITS-1:0]  r_grid_height;

    // circle and scan state
    logic [COORD_BITS-1:0] r_scan_x, r_scan_y;
    logic [COORD_BITS-1:0] r_box_left, r_box_right, r_box_bottom;
    logic [COORD_BITS-1:0] r_center_x, r_center_y;
    logic [R2_BITS-1:0]    r_r2;
    logic [PEAK_BITS-1:0]  r_peak;
    logic                  r_active;

    // per-position working registers
    logic [COORD_BITS-1:0] r_px, r_py, r_dx, r_dy;
    logic                  r_plast;
    logic [SQ_BITS-1:0]    r_dx2, r_dy2;
    logic [D2_BITS-1:0]    r_d2;
    logic                  r_inside;
    logic [PROD_BITS-1:0]  r_rem;
    logic [DVS_BITS-1:0]   r_dvs;
    logic [PEAK_BITS-1:0]  r_quo;
    logic [CNT_BITS-1:0]   r_cnt;

    // output register
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_x, r_out_y;
    logic                  r_out_inside, r_out_last;
    logic [PEAK_BITS-1:0]  r_out_level;

    // start decode, scan end, divider compare and level
    logic [SIZE_BITS-1:0]  w_w, w_h, w_wm1, w_hm1;
    logic [RAD_BITS-1:0]   w_r;
    logic [PEAK_BITS-1:0]  w_peak;
    logic [COORD_BITS-1:0] w_left, w_top;
    logic [SIZE_BITS-1:0]  w_right_full, w_bottom_full, w_right, w_bottom;
    logic                  w_box_ok;
    logic                  w_final;
    logic                  w_ge;
    logic [PEAK_BITS-1:0]  w_level;

    always_comb begin
        w_w    = (r_grid_width  > COORD_LIMIT) ? COORD_LIMIT : r_grid_width;
        w_h    = (r_grid_height > COORD_LIMIT) ? COORD_LIMIT : r_grid_height;
        w_wm1  = w_w - SIZE_BITS'(1);
        w_hm1  = w_h - SIZE_BITS'(1);
        w_r    = (int'(i_radius) > RADIUS_MAX) ? RAD_BITS'(RADIUS_MAX) : i_radius;
        w_peak = (int'(i_max_intensity) > PEAK_MAX) ? PEAK_BITS'(PEAK_MAX)
                                                    : i_max_intensity;
        w_left = ({2'b0, i_center_x} > (SIZE_BITS + 1)'(w_r))
               ? COORD_BITS'(i_center_x - COORD_BITS'(w_r)) : '0;
        w_top  = ({2'b0, i_center_y} > (SIZE_BITS + 1)'(w_r))
               ? COORD_BITS'(i_center_y - COORD_BITS'(w_r)) : '0;
        w_right_full  = SIZE_BITS'(i_center_x) + SIZE_BITS'(w_r);
        w_bottom_full = SIZE_BITS'(i_center_y) + SIZE_BITS'(w_r);
        w_right  = (w_right_full  > w_wm1) ? w_wm1 : w_right_full;
        w_bottom = (w_bottom_full > w_hm1) ? w_hm1 : w_bottom_full;
        w_box_ok = (w_w != '0) && (w_h != '0)
                && (SIZE_BITS'(w_left) <= w_right) && (SIZE_BITS'(w_top) <= w_bottom);
        w_final  = (r_scan_x == r_box_right) && (r_scan_y == r_box_bottom);
        w_ge     = (r_rem >= PROD_BITS'(r_dvs));
        if (!r_inside) begin
            w_level = '0;
        end else if (r_r2 == '0) begin
            w_level = r_peak;
        end else begin
            w_level = r_peak - r_quo;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= SIZE_RESET;
            r_grid_height <= SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == REG_GRID_WIDTH) begin
                r_grid_width <= i_cfg_wdata;
            end else begin
                r_grid_height <= i_cfg_wdata;
            end
        end
    end

    // active flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_cmd.latch_circle) begin
            r_active <= w_box_ok;
        end else if (i_cmd.capture_point && w_final) begin
            r_active <= 1'b0;
        end
    end

    // circle latch and scan advance
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_circle && w_box_ok) begin
            r_center_x   <= i_center_x;
            r_center_y   <= i_center_y;
            r_r2         <= R2_BITS'(w_r) * R2_BITS'(w_r);
            r_peak       <= w_peak;
            r_box_left   <= w_left;
            r_box_right  <= COORD_BITS'(w_right);
            r_box_bottom <= COORD_BITS'(w_bottom);
            r_scan_x     <= w_left;
            r_scan_y     <= w_top;
        end else if (i_cmd.capture_point) begin
            r_px    <= r_scan_x;
            r_py    <= r_scan_y;
            r_plast <= w_final;
            r_dx    <= (r_scan_x >= r_center_x) ? r_scan_x - r_center_x
                                                : r_center_x - r_scan_x;
            r_dy    <= (r_scan_y >= r_center_y) ? r_scan_y - r_center_y
                                                : r_center_y - r_scan_y;
            if (!w_final) begin
                if (r_scan_x >= r_box_right) begin
                    r_scan_x <= r_box_left;
                    r_scan_y <= r_scan_y + COORD_BITS'(1);
                end else begin
                    r_scan_x <= r_scan_x + COORD_BITS'(1);
                end
            end
        end
    end

    // distance, product and restoring divide
    always_ff @(posedge i_clk) begin
        if (i_cmd.square) begin
            r_dx2 <= SQ_BITS'(r_dx) * SQ_BITS'(r_dx);
            r_dy2 <= SQ_BITS'(r_dy) * SQ_BITS'(r_dy);
        end
        if (i_cmd.sum) begin
            r_d2     <= D2_BITS'(r_dx2) + D2_BITS'(r_dy2);
            r_inside <= (32'(r_dx2) + 32'(r_dy2)) <= 32'(r_r2);
        end
        if (i_cmd.mul) begin
            r_rem <= PROD_BITS'(r_peak) * PROD_BITS'(R2_BITS'(r_d2));
            r_dvs <= {r_r2, (PEAK_BITS - 1)'(0)};
            r_quo <= '0;
            r_cnt <= CNT_BITS'(DIV_STEPS - 1);
        end
        if (i_cmd.div_step) begin
            if (w_ge) begin
                r_rem <= r_rem - PROD_BITS'(r_dvs);
            end
            r_quo <= {r_quo[PEAK_BITS-2:0], w_ge};
            r_dvs <= r_dvs >> 1;
            r_cnt <= r_cnt - CNT_BITS'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_x      <= r_px;
            r_out_y      <= r_py;
            r_out_inside <= r_inside;
            r_out_level  <= w_level;
            r_out_last   <= r_plast;
        end
    end

    assign o_status.active   = r_active;
    assign o_status.div_done = (r_cnt == '0);
    assign o_status.out_free = !r_out_valid || i_ready;

    assign o_valid      = r_out_valid;
    assign o_point_x    = r_out_x;
    assign o_point_y    = r_out_y;
    assign o_inside_res = r_out_inside;
    assign o_intensity  = r_out_level;
    assign o_last       = r_out_last;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_ready))
        else $error("output register overwritten before it was taken");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (int'(w_level) <= PEAK_MAX))
        else $error("intensity above peak limit");

    a_outside_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_out && !r_inside) |=> (o_intensity == '0))
        else $error("outside position with nonzero intensity");

endmodule

// ===== hw/rtl/cone_falloff_circle_scan.sv =====
// Top level of the cone falloff circle scan block.
// Joins the controller (cfcs_ctrl) and the datapath (cfcs_dp); uses cfcs_pkg.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one transaction per item. Opcode
//   start latches a circle (center, radius, peak) and its bounding box clipped
//   to the grid; it gives no result. Opcode next emits one position of the
//   box, row by row and left to right, with inside flag, cone intensity
//   peak - peak*d2/r2 (truncated, zero outside), and last on the final box position. A next
//   with no active circle is dropped without a result.
//   Output channel (o_valid/i_ready) is fed from an output register.
//   Configuration: i_cfg_wr_en writes i_cfg_wdata to grid width (index 0) or
//   grid height (index 1); write only while the block is idle. Sizes apply
//   at the next start.
// Sequence:
//   A start is taken in the idle state. A next runs from acceptance through
//   square, sum, multiply, 7 divider steps (one quotient bit per cycle, set
//   by the 7-bit intensity quotient) and load; the load step writes the
//   result to the output register, and o_ready returns after the load.
// Reset: synchronous, active low; clears the active circle and the output
//   valid, sets both grid sizes to 1024.
// Stall: a finished result waits in the load step until the output register
//   is free, so o_ready stays low while it is full and i_ready is low.
module cone_falloff_circle_scan (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic                             i_cfg_index,
    input  logic [cfcs_pkg::SIZE_BITS-1:0]   i_cfg_wdata,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_opcode,
    input  logic [cfcs_pkg::COORD_BITS-1:0]  i_center_x,
    input  logic [cfcs_pkg::COORD_BITS-1:0]  i_center_y,
    input  logic [cfcs_pkg::RAD_BITS-1:0]    i_radius,
    input  logic [cfcs_pkg::PEAK_BITS-1:0]   i_max_intensity,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [cfcs_pkg::COORD_BITS-1:0]  o_point_x,
    output logic [cfcs_pkg::COORD_BITS-1:0]  o_point_y,
    output logic                             o_inside_res,
    output logic [cfcs_pkg::PEAK_BITS-1:0]   o_intensity,
    output logic                             o_last
);
    import cfcs_pkg::*;

    // commands flow from controller to datapath, status flows back
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    cfcs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    cfcs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_radius        (i_radius),
        .i_max_intensity (i_max_intensity),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_point_x       (o_point_x),
        .o_point_y       (o_point_y),
        .o_inside_res    (o_inside_res),
        .o_intensity     (o_intensity),
        .o_last          (o_last)
    );

endmodule
